>>> src/a64std_pkg.sv
// Shared types and constants for the arm64 stub target decoder.
package a64std_pkg;

  // Instruction pattern masks and match values
  localparam logic [31:0] ADRP16_MASK    = 32'h9F00001F;
  localparam logic [31:0] ADRP16_VAL     = 32'h90000010;
  localparam logic [31:0] ADRP_ANY_MASK  = 32'h9F000000;
  localparam logic [31:0] ADRP_ANY_VAL   = 32'h90000000;
  localparam logic [31:0] LDR16_MASK     = 32'hBFC003FF;
  localparam logic [31:0] LDR16_VAL      = 32'hB9400210;
  localparam logic [31:0] ADD16_MASK     = 32'hFFC003FF;
  localparam logic [31:0] ADD16_VAL      = 32'h91000210;
  localparam logic [31:0] ADD_ANY_MASK   = 32'hFFC00000;
  localparam logic [31:0] ADD_ANY_VAL    = 32'h91000000;
  localparam logic [31:0] LDR_ANY_MASK   = 32'hBFC00000;
  localparam logic [31:0] LDR_ANY_VAL    = 32'hB9400000;
  localparam logic [31:0] BRAA_MASK      = 32'hFEFFF800;
  localparam logic [31:0] BRAA_VAL       = 32'hD61F0800;
  localparam logic [31:0] BR_X16         = 32'hD61F0200;
  localparam logic [31:0] BRK_ONE        = 32'hD4200020;

  // Widths of the add immediate, the scaled load offset and their sum
  localparam int unsigned ADD_W = 12;
  localparam int unsigned LDR_W = 15;
  localparam int unsigned OFF_W = 16;

  typedef enum logic [2:0] {
    KIND_NORMAL         = 3'd0,
    KIND_OPTIMIZED      = 3'd1,
    KIND_AUTH_NORMAL    = 3'd2,
    KIND_AUTH_OPTIMIZED = 3'd3,
    KIND_AUTH_RESOLVER  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [63:0] stub_address;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
  } in_t;

  typedef struct packed {
    logic        matched;
    logic [2:0]  stub_kind;
    logic [63:0] resolved_address;
    logic        is_pointer_slot;
  } out_t;

  // Decode stage result handed to the address stages
  typedef struct packed {
    logic             valid;
    logic             matched;
    kind_t            kind;
    logic             slot;
    logic [63:0]      base;
    logic [63:0]      imm;
    logic [ADD_W-1:0] off_add;
    logic [LDR_W-1:0] off_ldr;
  } dec_t;

  // Wrap an address to 32 bits when requested
  function automatic logic [63:0] wrap_addr(input logic p32, input logic [63:0] v);
    wrap_addr = p32 ? {32'b0, v[31:0]} : v;
  endfunction

endpackage

>>> src/arm64_stub_target_decoder.sv
// Top level of the arm64 stub target decoder.
//
// Usage: drive in_data (stub address and the four instruction words found
// there) and raise start; a transaction is taken at each rising edge with
// start high and busy low. busy is always low, so one stub may be issued
// every cycle.
// Each transaction yields exactly one result on out_data, shown for a
// single cycle with out_strobe high; out_strobe rises once the stub has
// moved through the decode and page/offset sum registers into the final
// add register. The receiver cannot stall, so results stream out in issue order.
// Stages: decode register, page/offset sum register, final add register.
// Throughput: 1 transaction per cycle; the 64-bit page add and the final
// offset add each own a stage.
// Configuration: cfg_data sets pointer_is_32bit (wrap addresses to 32 bits)
// on a cfg_valid/cfg_ready transaction; cfg_ready is always high. Write it
// only while no transaction is in flight.
// Reset (rst_n low, synchronous) clears all valid bits and sets 64-bit
// address arithmetic.
module arm64_stub_target_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  a64std_pkg::in_t   in_data,
  output logic              out_strobe,
  output a64std_pkg::out_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import a64std_pkg::*;

  logic p32_r;
  logic in_fire;
  dec_t dec;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  // Hold the pointer width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p32_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      p32_r <= cfg_data;
    end
  end

  a64std_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .p32     (p32_r),
    .dec     (dec)
  );

  a64std_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec     (dec),
    .p32     (p32_r),
    .out_vld (out_strobe),
    .out_res (out_data)
  );

endmodule

>>> src/a64std_decode.sv
// Pattern match and immediate extraction stage, registered.
module a64std_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  a64std_pkg::in_t    in_data,
  input  logic               p32,
  output a64std_pkg::dec_t   dec
);
  import a64std_pkg::*;

  logic [31:0]      w0, w1, w2, w3;
  logic [63:0]      addr_w;
  logic [32:0]      imm33;
  logic             adrp16, adrp_any;
  logic             m_norm, m_opt, m_anorm, m_aopt, m_ares;
  logic [ADD_W-1:0] add1;
  logic [LDR_W-1:0] ldr1, ldr2;
  dec_t             dec_nxt, dec_r;

  assign w0 = in_data.word_zero;
  assign w1 = in_data.word_one;
  assign w2 = in_data.word_two;
  assign w3 = in_data.word_three;

  // Match the five patterns
  assign adrp16   = (w0 & ADRP16_MASK) == ADRP16_VAL;
  assign adrp_any = (w0 & ADRP_ANY_MASK) == ADRP_ANY_VAL;
  assign m_norm   = adrp16 && ((w1 & LDR16_MASK) == LDR16_VAL) && (w2 == BR_X16);
  assign m_opt    = adrp16 && ((w1 & ADD16_MASK) == ADD16_VAL) && (w2 == BR_X16);
  assign m_anorm  = adrp_any && ((w1 & ADD_ANY_MASK) == ADD_ANY_VAL) &&
                    ((w2 & LDR_ANY_MASK) == LDR_ANY_VAL) &&
                    ((w3 & BRAA_MASK) == BRAA_VAL);
  assign m_aopt   = adrp_any && ((w1 & ADD_ANY_MASK) == ADD_ANY_VAL) &&
                    (w2 == BR_X16) && (w3 == BRK_ONE);
  assign m_ares   = adrp_any && ((w1 & LDR_ANY_MASK) == LDR_ANY_VAL) &&
                    ((w2 & BRAA_MASK) == BRAA_VAL);

  // Extract immediates
  assign addr_w = wrap_addr(p32, in_data.stub_address);
  assign imm33  = {w0[23:5], w0[30:29], 12'b0};
  assign add1   = w1[21:10];
  assign ldr1   = {3'b0, w1[21:10]} << w1[31:30];
  assign ldr2   = {3'b0, w2[21:10]} << w2[31:30];

  // Select the first matching pattern in priority order
  always_comb begin
    dec_nxt         = '0;
    dec_nxt.valid   = in_fire;
    dec_nxt.base    = {addr_w[63:12], 12'b0};
    dec_nxt.imm     = {{31{imm33[32]}}, imm33};
    dec_nxt.matched = 1'b1;
    dec_nxt.kind    = KIND_NORMAL;
    if (m_norm) begin
      dec_nxt.slot    = 1'b1;
      dec_nxt.off_ldr = ldr1;
    end else if (m_opt) begin
      dec_nxt.kind    = KIND_OPTIMIZED;
      dec_nxt.off_add = add1;
    end else if (m_anorm) begin
      dec_nxt.kind    = KIND_AUTH_NORMAL;
      dec_nxt.slot    = 1'b1;
      dec_nxt.off_add = add1;
      dec_nxt.off_ldr = ldr2;
    end else if (m_aopt) begin
      dec_nxt.kind    = KIND_AUTH_OPTIMIZED;
      dec_nxt.off_add = add1;
    end else if (m_ares) begin
      dec_nxt.kind    = KIND_AUTH_RESOLVER;
      dec_nxt.slot    = 1'b1;
      dec_nxt.off_ldr = ldr1;
    end else begin
      dec_nxt.matched = 1'b0;
    end
  end

  // Advance the decode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r.valid <= dec_nxt.valid;
    end
    dec_r.matched <= dec_nxt.matched;
    dec_r.kind    <= dec_nxt.kind;
    dec_r.slot    <= dec_nxt.slot;
    dec_r.base    <= dec_nxt.base;
    dec_r.imm     <= dec_nxt.imm;
    dec_r.off_add <= dec_nxt.off_add;
    dec_r.off_ldr <= dec_nxt.off_ldr;
  end

  assign dec = dec_r;

endmodule

>>> src/a64std_addr.sv
// Two address stages: page sum with offset sum, then the final add.
module a64std_addr (
  input  logic               clk,
  input  logic               rst_n,
  input  a64std_pkg::dec_t   dec,
  input  logic               p32,
  output logic               out_vld,
  output a64std_pkg::out_t   out_res
);
  import a64std_pkg::*;

  logic             v2_r;
  logic             m2_r, slot2_r;
  kind_t            kind2_r;
  logic [63:0]      page2_r, page2_nxt;
  logic [OFF_W-1:0] off2_r, off2_nxt;
  logic             v3_r;
  out_t             res3_r, res3_nxt;

  // Form the page address and combine the small offsets
  assign page2_nxt = wrap_addr(p32, dec.base + dec.imm);
  assign off2_nxt  = OFF_W'(dec.off_add) + OFF_W'(dec.off_ldr);

  // Add offset to page; drop everything for an unmatched stub
  always_comb begin
    res3_nxt = '0;
    if (m2_r) begin
      res3_nxt.matched          = 1'b1;
      res3_nxt.stub_kind        = kind2_r;
      res3_nxt.is_pointer_slot  = slot2_r;
      res3_nxt.resolved_address = wrap_addr(p32, page2_r + {{(64-OFF_W){1'b0}}, off2_r});
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= dec.valid;
      v3_r <= v2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    m2_r    <= dec.matched;
    slot2_r <= dec.slot;
    kind2_r <= dec.kind;
    page2_r <= page2_nxt;
    off2_r  <= off2_nxt;
    res3_r  <= res3_nxt;
  end

  assign out_vld = v3_r;
  assign out_res = res3_r;

endmodule

>>> tb/tb_arm64_stub_target_decoder.sv
// Self-checking testbench for the arm64 stub target decoder.
module tb_arm64_stub_target_decoder;
  import a64std_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;

  // Stub shapes the random generator builds
  typedef enum int {
    SHAPE_NORMAL,
    SHAPE_OPTIMIZED,
    SHAPE_AUTH_NORMAL,
    SHAPE_AUTH_OPTIMIZED,
    SHAPE_AUTH_RESOLVER
  } shape_t;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic start      = 1'b0;
  logic busy;
  in_t  in_data    = '0;
  logic out_strobe;
  out_t out_data;
  logic cfg_valid  = 1'b0;
  logic cfg_ready;
  logic cfg_data   = 1'b0;

  // Local copy of the pointer width register, plus scoreboard state
  logic narrow_mode    = 1'b0;
  int   gap_pct        = 0;
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  out_t expected_decodes[$];

  arm64_stub_target_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Add immediate, bits 21:10
  function automatic logic [63:0] add_field(input logic [31:0] w);
    return {52'b0, w[21:10]};
  endfunction

  // Unsigned load offset, scaled by the size bits
  function automatic logic [63:0] ldr_field(input logic [31:0] w);
    return add_field(w) << w[31:30];
  endfunction

  // Decode one stub the way the block should
  function automatic out_t predict_stub(input in_t s, input logic narrow);
    logic [63:0] keep;
    logic [63:0] page;
    logic [63:0] imm;
    logic [32:0] page_off;
    logic        adrp_x16;
    logic        adrp_any;
    out_t        r;
    keep     = narrow ? 64'h0000_0000_FFFF_FFFF : {64{1'b1}};
    page_off = {s.word_zero[23:5], s.word_zero[30:29], 12'h000};
    imm      = {{31{page_off[32]}}, page_off};
    page     = (((s.stub_address & keep) & ~64'hFFF) + imm) & keep;
    adrp_x16 = (s.word_zero & ADRP16_MASK) == ADRP16_VAL;
    adrp_any = (s.word_zero & ADRP_ANY_MASK) == ADRP_ANY_VAL;
    r = '0;
    r.matched = 1'b1;
    // Try the patterns in priority order
    if (adrp_x16 && (s.word_one & LDR16_MASK) == LDR16_VAL && s.word_two == BR_X16) begin
      r.stub_kind        = KIND_NORMAL;
      r.resolved_address = page + ldr_field(s.word_one);
      r.is_pointer_slot  = 1'b1;
    end else if (adrp_x16 && (s.word_one & ADD16_MASK) == ADD16_VAL &&
                 s.word_two == BR_X16) begin
      r.stub_kind        = KIND_OPTIMIZED;
      r.resolved_address = page + add_field(s.word_one);
    end else if (adrp_any && (s.word_one & ADD_ANY_MASK) == ADD_ANY_VAL &&
                 (s.word_two & LDR_ANY_MASK) == LDR_ANY_VAL &&
                 (s.word_three & BRAA_MASK) == BRAA_VAL) begin
      r.stub_kind        = KIND_AUTH_NORMAL;
      r.resolved_address = page + add_field(s.word_one) + ldr_field(s.word_two);
      r.is_pointer_slot  = 1'b1;
    end else if (adrp_any && (s.word_one & ADD_ANY_MASK) == ADD_ANY_VAL &&
                 s.word_two == BR_X16 && s.word_three == BRK_ONE) begin
      r.stub_kind        = KIND_AUTH_OPTIMIZED;
      r.resolved_address = page + add_field(s.word_one);
    end else if (adrp_any && (s.word_one & LDR_ANY_MASK) == LDR_ANY_VAL &&
                 (s.word_two & BRAA_MASK) == BRAA_VAL) begin
      r.stub_kind        = KIND_AUTH_RESOLVER;
      r.resolved_address = page + ldr_field(s.word_one);
      r.is_pointer_slot  = 1'b1;
    end else begin
      r.matched = 1'b0;
    end
    r.resolved_address = r.resolved_address & keep;
    return r;
  endfunction

  function automatic in_t make_stub(input logic [63:0] a, input logic [31:0] w0,
                                    input logic [31:0] w1, input logic [31:0] w2,
                                    input logic [31:0] w3);
    in_t s;
    s.stub_address = a;
    s.word_zero    = w0;
    s.word_one     = w1;
    s.word_two     = w2;
    s.word_three   = w3;
    return s;
  endfunction

  // Mix random addresses with some near the top of the space so sums wrap
  function automatic logic [63:0] rand_address();
    case ($urandom_range(0, 7))
      0:       return {64{1'b1}} - $urandom_range(0, 8191);
      1:       return {32'h0, $urandom()};
      2:       return {32'hFFFF_FFFF, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Build a well-formed stub of one shape with random free fields
  function automatic in_t build_stub(input shape_t shape);
    in_t         s;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    r0 = $urandom();
    r1 = $urandom();
    r2 = $urandom();
    r3 = $urandom();
    s.stub_address = rand_address();
    s.word_zero    = ADRP_ANY_VAL | (r0 & ~ADRP_ANY_MASK);
    if ($urandom_range(0, 3) == 0) s.word_zero[4:0] = 5'd16;
    s.word_one   = r1;
    s.word_two   = r2;
    s.word_three = r3;
    case (shape)
      SHAPE_NORMAL: begin
        s.word_zero = ADRP16_VAL | (r0 & ~ADRP16_MASK);
        s.word_one  = LDR16_VAL | (r1 & ~LDR16_MASK);
        s.word_two  = BR_X16;
      end
      SHAPE_OPTIMIZED: begin
        s.word_zero = ADRP16_VAL | (r0 & ~ADRP16_MASK);
        s.word_one  = ADD16_VAL | (r1 & ~ADD16_MASK);
        s.word_two  = BR_X16;
        if ($urandom_range(0, 2) == 0) s.word_three = BRK_ONE;
      end
      SHAPE_AUTH_NORMAL: begin
        s.word_one   = ADD_ANY_VAL | (r1 & ~ADD_ANY_MASK);
        s.word_two   = LDR_ANY_VAL | (r2 & ~LDR_ANY_MASK);
        s.word_three = BRAA_VAL | (r3 & ~BRAA_MASK);
      end
      SHAPE_AUTH_OPTIMIZED: begin
        s.word_one   = ADD_ANY_VAL | (r1 & ~ADD_ANY_MASK);
        s.word_two   = BR_X16;
        s.word_three = BRK_ONE;
      end
      default: begin
        s.word_one = LDR_ANY_VAL | (r1 & ~LDR_ANY_MASK);
        s.word_two = BRAA_VAL | (r2 & ~BRAA_MASK);
      end
    endcase
    return s;
  endfunction

  // Issue one stub, optionally idle first, and log its expected decode
  task automatic send_stub(input in_t s);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_decodes.insert(expected_decodes.size(), predict_stub(s, narrow_mode));
  endtask

  // Drain the pipeline, then write the pointer width register
  task automatic write_pointer_mode(input logic narrow);
    start <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= narrow;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    narrow_mode = narrow;
  endtask

  // Every format, priority overlaps, near misses and wrap at 64 bits
  task automatic test_directed_patterns();
    send_stub(make_stub(64'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_stub(make_stub({64{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
    send_stub(make_stub(64'h0, 32'hF07F_FFF0, 32'hF97F_FE10, BR_X16, 32'h0));
    send_stub(make_stub(64'h1234, 32'h9080_0010, 32'hB940_0210, BR_X16, 32'hFFFF_FFFF));
    send_stub(make_stub(64'hFFFF_FFFF_FFFF_F000, 32'h9000_0030, 32'hB97F_FE10, BR_X16,
                        32'h0));
    send_stub(make_stub({64{1'b1}}, 32'hB000_0010, 32'h913F_FE10, BR_X16, 32'h0));
    send_stub(make_stub(64'h0000_7FFF_0000_0ABC, 32'h9000_0010, 32'h9100_0210, BR_X16,
                        BRK_ONE));
    send_stub(make_stub(64'h0000_0001_8000_0FFF, 32'h9000_0011, 32'h9123_4567,
                        32'hF971_2345, 32'hD71F_0A5A));
    send_stub(make_stub({64{1'b1}}, 32'hF07F_FFE0, 32'h913F_FC00, 32'hF97F_FFFF,
                        32'hD71F_0FFF));
    send_stub(make_stub(64'h8000_0000_0000_0000, 32'hF0FF_FFE3, 32'h913F_FC00, BR_X16,
                        BRK_ONE));
    send_stub(make_stub(64'h1000, 32'h9000_0000, 32'h9100_0210, BR_X16, BRK_ONE));
    send_stub(make_stub(64'h1000, 32'h9000_0000, 32'h9100_0210, BR_X16, 32'hD420_0021));
    send_stub(make_stub(64'hFFFF_FFFF_0000_0000, 32'h9000_001F, 32'hB97F_FFFF,
                        32'hD61F_0BFF, 32'hFFFF_FFFF));
    send_stub(make_stub(64'h0123_4567_89AB_CDEF, 32'h90FF_FFE1, 32'hF940_0400,
                        32'hD71F_0800, 32'h0));
    send_stub(make_stub(64'h4000, 32'h9000_0010, 32'hB940_0210, 32'hD61F_0201, 32'h0));
    send_stub(make_stub(64'h4000, 32'h1000_0010, 32'hB940_0210, BR_X16, 32'h0));
    send_stub(make_stub(64'h4000, 32'h9000_0011, 32'h9123_4567, 32'hF971_2345,
                        32'hD61F_0000));
  endtask

  // Same shapes with 32-bit pointers, where sums wrap at 2^32
  task automatic test_narrow_pointer();
    write_pointer_mode(1'b1);
    send_stub(make_stub(64'hFFFF_FFFF_FFFF_F123, 32'hF07F_FFF0, 32'hF97F_FE10, BR_X16,
                        32'h0));
    send_stub(make_stub(64'h10, 32'h9080_0010, 32'hB940_0210, BR_X16, 32'h0));
    send_stub(make_stub(64'hDEAD_BEEF_FFFF_F000, 32'hF07F_FFE0, 32'h913F_FC00,
                        32'hF97F_FFFF, 32'hD71F_0FFF));
    send_stub(make_stub({64{1'b1}}, 32'hB000_0010, 32'h913F_FE10, BR_X16, 32'h0));
    send_stub(make_stub({64{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
    send_stub(make_stub(64'h1_0000_0000, 32'h9000_001F, 32'hB97F_FFFF, 32'hD61F_0BFF,
                        32'h0));
  endtask

  // Mostly well-formed stubs, some with one flipped bit, some pure noise
  task automatic test_random_stubs(input int count, input bit with_gaps);
    in_t          s;
    int           pick;
    int           flip;
    logic [127:0] words;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        gap_pct = (with_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(5, 35) : 0;
      pick = $urandom_range(1, 100);
      s    = build_stub(shape_t'($urandom_range(0, 4)));
      if (pick > 85) begin
        s.word_zero  = $urandom();
        s.word_one   = $urandom();
        s.word_two   = $urandom();
        s.word_three = $urandom();
      end else if (pick > 70) begin
        words       = {s.word_zero, s.word_one, s.word_two, s.word_three};
        flip        = $urandom_range(0, 127);
        words[flip] = ~words[flip];
        {s.word_zero, s.word_one, s.word_two, s.word_three} = words;
      end
      send_stub(s);
    end
  endtask

  // Compare each result against the oldest expected decode
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (expected_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected decode result: %h", out_data);
      end else begin
        want = expected_decodes.pop_front();
        if (out_data.matched !== want.matched || out_data.stub_kind !== want.stub_kind ||
            out_data.resolved_address !== want.resolved_address ||
            out_data.is_pointer_slot !== want.is_pointer_slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("decode mismatch: expected matched=%b kind=%0d addr=%h slot=%b,",
                     want.matched, want.stub_kind, want.resolved_address,
                     want.is_pointer_slot,
                     " got matched=%b kind=%0d addr=%h slot=%b",
                     out_data.matched, out_data.stub_kind,
                     out_data.resolved_address, out_data.is_pointer_slot);
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transaction on any port
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("arm64_stub_target_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_pointer_mode(1'b0);
    gap_pct = 20;
    test_directed_patterns();
    test_narrow_pointer();
    test_random_stubs(250, 1'b1);
    write_pointer_mode(1'b0);
    test_random_stubs(300, 1'b1);
    write_pointer_mode(1'b1);
    test_random_stubs(50, 1'b1);
    test_random_stubs(130, 1'b0);
    // Let the pipeline empty before judging
    start <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("arm64_stub_target_decoder regression: pass");
    else
      $display("arm64_stub_target_decoder regression: fail");
    $finish;
  end

endmodule

>>> arm64_stub_target_decoder.f
src/a64std_pkg.sv
src/a64std_decode.sv
src/a64std_addr.sv
src/arm64_stub_target_decoder.sv
tb/tb_arm64_stub_target_decoder.sv
